// File: hdl/cbpg_pkg.sv
// Shared types and constants for the cubic Bezier point generator.
// No dependencies; every other file imports this package.
package cbpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int T_BITS     = 16;
  localparam int NUM_REGS   = 8;
  localparam int IDX_BITS   = 4;
  localparam logic [T_BITS:0] STEP = (T_BITS+1)'(492);

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [T_BITS-1:0]     tparam_t;
  typedef logic [IDX_BITS-1:0]   reg_idx_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_PUSH
  } cbpg_state_t;

  // Interpolation steps of the de Casteljau construction
  typedef enum logic [2:0] {
    LERP_A,   // P0..P1
    LERP_B,   // P1..P2
    LERP_C,   // P2..P3
    LERP_M,   // A..B
    LERP_N,   // B..C
    LERP_R    // M..N, the curve point
  } lerp_step_t;

  typedef struct packed {
    logic       accept;
    logic       calc;
    lerp_step_t step;
    logic       load_out;
  } cbpg_cmd_t;

endpackage

// File: hdl/cbpg_if.sv
// Item channel interfaces for the cubic Bezier point generator.
// Depends on cbpg_pkg for the coordinate type.
interface cbpg_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface cbpg_rsp_if
  import cbpg_pkg::*;
;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

// File: hdl/cbpg_ctrl.sv
// Sequencer for the cubic Bezier point generator: accepts an item, steps the
// datapath through six interpolations and hands the point to the output register.
// Depends on cbpg_pkg.
module cbpg_ctrl
  import cbpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output cbpg_cmd_t cmd
);

  cbpg_state_t state, state_next;
  lerp_step_t  step, step_next;
  logic        out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_CALC;
      end
      ST_CALC: begin
        if (step == LERP_R) state_next = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    case (step)
      LERP_A:  step_next = LERP_B;
      LERP_B:  step_next = LERP_C;
      LERP_C:  step_next = LERP_M;
      LERP_M:  step_next = LERP_N;
      LERP_N:  step_next = LERP_R;
      default: step_next = LERP_A;
    endcase
  end

  always_comb begin
    req_ready    = (state == ST_IDLE);
    cmd.accept   = (state == ST_IDLE) && req_valid;
    cmd.calc     = (state == ST_CALC);
    cmd.step     = step;
    cmd.load_out = (state == ST_PUSH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= LERP_A;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.calc) step <= step_next;
      else          step <= LERP_A;
      if (cmd.load_out)   rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

endmodule

// File: hdl/cbpg_datapath.sv
// Datapath of the cubic Bezier point generator: control point registers,
// curve parameter, one interpolation unit per axis and the output register.
// Depends on cbpg_pkg.
module cbpg_datapath
  import cbpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  reg_idx_t  cfg_index,
  input  coord_t    cfg_data,
  input  logic      restart,
  input  cbpg_cmd_t cmd,
  output coord_t    point_x,
  output coord_t    point_y,
  output logic      last_point
);

  // floor(a + (b - a) * t / 2^T_BITS), exact for either direction
  function automatic coord_t lerp_floor(coord_t a, coord_t b, tparam_t t);
    logic signed [COORD_BITS:0]          diff;
    logic signed [COORD_BITS+T_BITS+1:0] prod;
    logic signed [COORD_BITS+1:0]        sum;
    diff = $signed({1'b0, b}) - $signed({1'b0, a});
    prod = diff * $signed({1'b0, t});
    sum  = $signed({2'b00, a}) + $signed(prod[COORD_BITS+T_BITS+1:T_BITS]);
    return sum[COORD_BITS-1:0];
  endfunction

  coord_t  cp [2][4];        // [axis][control point]
  tparam_t curve_param;
  tparam_t t_cur;
  logic    last_cur;

  tparam_t         t_use;
  logic [T_BITS:0] t_sum;

  assign t_use = restart ? '0 : curve_param;
  assign t_sum = {1'b0, t_use} + STEP;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_param <= '0;
      for (int ax = 0; ax < 2; ax++) begin
        for (int k = 0; k < 4; k++) cp[ax][k] <= '0;
      end
    end else begin
      if (cfg_we && (cfg_index < reg_idx_t'(NUM_REGS)))
        cp[cfg_index[0]][cfg_index[2:1]] <= cfg_data;
      if (cmd.accept)
        curve_param <= t_sum[T_BITS] ? '0 : t_sum[T_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      t_cur    <= t_use;
      last_cur <= t_sum[T_BITS];
    end
  end

  coord_t pt [2];

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    coord_t ra, rb, rc, rm, rn, rr;
    coord_t op_a, op_b, res;

    always_comb begin
      case (cmd.step)
        LERP_A:  begin op_a = cp[ax][0]; op_b = cp[ax][1]; end
        LERP_B:  begin op_a = cp[ax][1]; op_b = cp[ax][2]; end
        LERP_C:  begin op_a = cp[ax][2]; op_b = cp[ax][3]; end
        LERP_M:  begin op_a = ra;        op_b = rb;        end
        LERP_N:  begin op_a = rb;        op_b = rc;        end
        default: begin op_a = rm;        op_b = rn;        end
      endcase
    end

    assign res = lerp_floor(op_a, op_b, t_cur);

    always_ff @(posedge clk) begin
      if (cmd.calc) begin
        case (cmd.step)
          LERP_A:  ra <= res;
          LERP_B:  rb <= res;
          LERP_C:  rc <= res;
          LERP_M:  rm <= res;
          LERP_N:  rn <= res;
          default: rr <= res;
        endcase
      end
    end

    assign pt[ax] = rr;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      point_x    <= pt[0];
      point_y    <= pt[1];
      last_point <= last_cur;
    end
  end

endmodule

// File: hdl/cubic_bezier_point_generator.sv
// Cubic Bezier point generator: each request item yields one curve point,
// computed by de Casteljau's construction with floor after every interpolation.
// Each item is accepted, then makes six passes through the shared per-axis
// interpolation unit (one 13x17 multiply each), then is loaded into the output
// register. The next item is accepted while a finished point still waits in
// the output register. The curve parameter t is Q0.16 and advances by 492
// per point; the point whose next step reaches 1.0 is flagged last and t
// restarts at 0. A request with restart set forces t to 0 first. Control
// points are written through cfg_we/cfg_index/cfg_data, indexes 0..7 in the
// order start x/y, ctrl1 x/y, ctrl2 x/y, end x/y; other indexes are ignored.
// Depends on cbpg_pkg, cbpg_if, cbpg_ctrl and cbpg_datapath.
module cubic_bezier_point_generator
  import cbpg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  reg_idx_t cfg_index,
  input  coord_t   cfg_data,
  cbpg_req_if.sink   req,
  cbpg_rsp_if.source rsp
);

  cbpg_cmd_t cmd;
  logic      req_ready;
  logic      rsp_valid;

  cbpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  cbpg_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .restart    (req.restart),
    .cmd        (cmd),
    .point_x    (rsp.point_x),
    .point_y    (rsp.point_y),
    .last_point (rsp.last_point)
  );

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;

endmodule

// File: hdl/cbpg_checker.sv
// Port-level checks for the cubic Bezier point generator, bound to the top level.
// Depends on cbpg_pkg.
module cbpg_checker
  import cbpg_pkg::*;
(
  input logic   clk,
  input logic   rst,
  input logic   req_valid,
  input logic   req_ready,
  input logic   rsp_valid,
  input logic   rsp_ready,
  input coord_t point_x,
  input coord_t point_y,
  input logic   last_point
);

  logic       req_fire, rsp_fire;
  logic [1:0] pending;

  assign req_fire = req_valid && req_ready;
  assign rsp_fire = rsp_valid && rsp_ready;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, req_fire} - {1'b0, rsp_fire};
    end
  end

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    rsp_fire |-> pending != 2'd0)
    else $error("point delivered with no item outstanding");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    req_ready |-> pending != 2'd2)
    else $error("request taken with two items already outstanding");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("point valid right after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("point dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=>
      $stable(point_x) && $stable(point_y) && $stable(last_point))
    else $error("point changed while stalled");

endmodule

bind cubic_bezier_point_generator cbpg_checker u_cbpg_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .point_x    (rsp.point_x),
  .point_y    (rsp.point_y),
  .last_point (rsp.last_point)
);

// File: sim/cubic_bezier_point_generator_tb.sv
// Self-checking testbench for cubic_bezier_point_generator: predicts every curve point
// from the control points and the running parameter t and checks each result item.
// Depends on cbpg_pkg, cbpg_if and the block itself.
module cubic_bezier_point_generator_tb;
  import cbpg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 20;
  localparam int MAX_WAIT    = 19;
  localparam int MAX_PRINTS  = 20;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } curve_pt_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     cfg_we;
  reg_idx_t cfg_index;
  coord_t   cfg_data;

  cbpg_req_if req_if();
  cbpg_rsp_if rsp_if();

  cubic_bezier_point_generator dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_if),
    .rsp(rsp_if)
  );

  // predictor state
  coord_t  ctrl_pts[NUM_REGS];
  tparam_t curve_t;

  logic      pending_restarts[$];
  curve_pt_t expected_points[$];

  logic req_busy;
  logic req_took;
  logic rsp_took;
  int   req_gap;
  int   rsp_stall;
  int   req_gap_max;
  int   rsp_stall_max;

  int cycle_count;
  int error_count;
  int points_checked;
  int last_points;
  int restarts_sent;
  int settings_used;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic coord_t lerp_down(coord_t a, coord_t b, tparam_t t);
    logic [31:0] prod;
    if (b >= a) begin
      prod = (32'(b) - 32'(a)) * 32'(t);
      return a + coord_t'(prod >> T_BITS);
    end else begin
      // descending span: round the drop up so the result still floors
      prod = (32'(a) - 32'(b)) * 32'(t);
      return a - coord_t'((prod + 32'((1 << T_BITS) - 1)) >> T_BITS);
    end
  endfunction

  function automatic coord_t bezier_axis(coord_t p0, coord_t p1, coord_t p2, coord_t p3,
                                         tparam_t t);
    coord_t a, b, c, m, n;
    a = lerp_down(p0, p1, t);
    b = lerp_down(p1, p2, t);
    c = lerp_down(p2, p3, t);
    m = lerp_down(a, b, t);
    n = lerp_down(b, c, t);
    return lerp_down(m, n, t);
  endfunction

  function automatic curve_pt_t predict_point(logic restart);
    curve_pt_t       p;
    logic [T_BITS:0] nxt;
    if (restart) curve_t = '0;
    p.x = bezier_axis(ctrl_pts[0], ctrl_pts[2], ctrl_pts[4], ctrl_pts[6], curve_t);
    p.y = bezier_axis(ctrl_pts[1], ctrl_pts[3], ctrl_pts[5], ctrl_pts[7], curve_t);
    nxt = {1'b0, curve_t} + STEP;
    p.last = nxt[T_BITS];
    // end of curve: t goes back to exactly zero
    curve_t = p.last ? '0 : nxt[T_BITS-1:0];
    return p;
  endfunction

  function automatic int draw_wait(int max_wait);
    if (max_wait == 0 || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, max_wait);
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (error_count < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_busy && req_took) req_busy = 1'b0;
      if (!req_busy) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (pending_restarts.size() > 0) begin
          req_if.restart <= pending_restarts[0];
          pending_restarts.delete(0);
          req_busy = 1'b1;
          req_gap = draw_wait(req_gap_max);
        end
      end
      req_if.valid <= req_busy;
    end
  end

  // result sink: stall a random number of cycles after each item
  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_took) rsp_stall = draw_wait(rsp_stall_max);
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on every accepted request, check every accepted result
  always @(posedge clk) begin
    curve_pt_t want;
    cycle_count++;
    req_took <= !rst && req_if.valid && req_if.ready;
    rsp_took <= !rst && rsp_if.valid && rsp_if.ready;
    if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        if (req_if.restart) restarts_sent++;
        expected_points.insert(expected_points.size(), predict_point(req_if.restart));
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_points.size() == 0) begin
          report_mismatch("unexpected point, x", int'(rsp_if.point_x), 0);
        end else begin
          want = expected_points[0];
          expected_points.delete(0);
          if (rsp_if.point_x !== want.x)
            report_mismatch("point_x", int'(rsp_if.point_x), int'(want.x));
          if (rsp_if.point_y !== want.y)
            report_mismatch("point_y", int'(rsp_if.point_y), int'(want.y));
          if (rsp_if.last_point !== want.last)
            report_mismatch("last_point", int'(rsp_if.last_point), int'(want.last));
          if (want.last) last_points++;
          points_checked++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_restarts.size() != 0 || req_busy || expected_points.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, coord_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    // indexes past the last register are ignored by the block
    if (idx < NUM_REGS) ctrl_pts[idx[2:0]] = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // reprogram only once the block has gone quiet
  task automatic load_curve(coord_t sx, coord_t sy, coord_t ax, coord_t ay,
                            coord_t bx, coord_t by, coord_t ex, coord_t ey);
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    write_reg(0, sx);
    write_reg(1, sy);
    write_reg(2, ax);
    write_reg(3, ay);
    write_reg(4, bx);
    write_reg(5, by);
    write_reg(6, ex);
    write_reg(7, ey);
    write_reg(reg_idx_t'($urandom_range(NUM_REGS, (1 << IDX_BITS) - 1)), coord_t'($urandom));
    settings_used++;
  endtask

  task automatic send_item(logic restart);
    while (pending_restarts.size() > 2) @(posedge clk);
    pending_restarts.insert(pending_restarts.size(), restart);
  endtask

  initial begin
    int restart_odds;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.restart = 1'b0;
    rsp_if.ready = 1'b0;
    req_busy = 1'b0;
    req_took = 1'b0;
    rsp_took = 1'b0;
    req_gap = 0;
    rsp_stall = 0;
    req_gap_max = 0;
    rsp_stall_max = 0;
    cycle_count = 0;
    error_count = 0;
    points_checked = 0;
    last_points = 0;
    restarts_sent = 0;
    settings_used = 0;
    curve_t = '0;
    foreach (ctrl_pts[i]) ctrl_pts[i] = '0;

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: reset control points, then all-ones, then alternating extremes
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    load_curve('1, '1, '1, '1, '1, '1, '1, '1);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    load_curve('0, '1, '1, '0, '0, '1, '1, '0);
    for (int i = 0; i < 8; i++) send_item(i == 5);
    req_gap_max = MAX_WAIT;
    rsp_stall_max = MAX_WAIT;
    load_curve('1, '0, '0, '1, '1, '0, '0, '1);
    for (int i = 0; i < 8; i++) begin
      // hold the sender until the block has emptied out
      if (i == 4) wait_drained();
      send_item(i == 0);
    end

    // random curves; the first runs without restarts so t wraps at the end of the curve
    for (int ph = 0; ph < 6; ph++) begin
      req_gap_max = (ph % 3 == 1) ? 0 : MAX_WAIT;
      rsp_stall_max = (ph % 2 == 1) ? 0 : MAX_WAIT;
      restart_odds = (ph == 0) ? 0 : (ph == 4) ? 4 : 250;
      load_curve(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                 pick_coord(), pick_coord(), pick_coord(), pick_coord());
      for (int i = 0; i < 200; i++) begin
        if ($urandom_range(0, 39) == 0) wait_drained();
        send_item(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (expected_points.size() != 0)
      report_mismatch("points never delivered", 0, expected_points.size());
    $display("covered %0d curve points over %0d control point sets", points_checked,
             settings_used);
    $display("%0d ends of curve, %0d restarts, %0d cycles", last_points, restarts_sent,
             cycle_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
